// ----- src/mse_pkg.sv -----
// ----------------------------------------------------------------------------
// mse_pkg
// Shared types, sizes and helper functions for the MIPS-subset execute unit.
// ----------------------------------------------------------------------------
package mse_pkg;

  // Datapath and field sizes
  localparam int XLEN    = 32;
  localparam int NREGS   = 32;
  localparam int REG_AW  = $clog2(NREGS);
  localparam int OP_W    = 4;
  localparam int TGT_W   = 10;
  localparam int BADDR_W = 12;
  localparam int HALF_W  = 16;

  // Store depths; both are powers of two so address wrap is a truncation
  localparam int DMEM_DEPTH = 1024;
  localparam int DMEM_AW    = $clog2(DMEM_DEPTH);
  localparam int IMEM_DEPTH = 1024;
  localparam int IMEM_AW    = $clog2(IMEM_DEPTH);

  // Decoded operation codes; the two unused codes execute as nop
  typedef enum logic [OP_W-1:0] {
    OP_NOP  = 4'd0,
    OP_LI   = 4'd1,
    OP_MOVE = 4'd2,
    OP_J    = 4'd3,
    OP_ADD  = 4'd4,
    OP_AND  = 4'd5,
    OP_SLT  = 4'd6,
    OP_ADDI = 4'd7,
    OP_ORI  = 4'd8,
    OP_LUI  = 4'd9,
    OP_LW   = 4'd10,
    OP_SW   = 4'd11,
    OP_BEQ  = 4'd12,
    OP_BNE  = 4'd13
  } op_t;

  // Execute stage outcome handed from the ALU to the pipeline control
  typedef struct packed {
    logic [XLEN-1:0]    result;
    logic               wr_en;
    logic               is_load;
    logic               is_store;
    logic               is_br;
    logic               taken;
    logic [DMEM_AW-1:0] mem_addr;
  } exec_t;

  // Sign-extend the low half word
  function automatic logic [XLEN-1:0] sext16(input logic [XLEN-1:0] v);
    return {{(XLEN-HALF_W){v[HALF_W-1]}}, v[HALF_W-1:0]};
  endfunction

  // Zero-extend the low half word
  function automatic logic [XLEN-1:0] zext16(input logic [XLEN-1:0] v);
    return {{(XLEN-HALF_W){1'b0}}, v[HALF_W-1:0]};
  endfunction

endpackage

// ----- src/mse_regfile.sv -----
// ----------------------------------------------------------------------------
// mse_regfile
// 32 x 32 register file, two registered read ports, one write port.
// Per-entry valid bits make unwritten entries read as zero after reset;
// entry 0 is never written and so always reads zero.
// ----------------------------------------------------------------------------
module mse_regfile (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       rd_en,
  input  logic [mse_pkg::REG_AW-1:0] ra_addr,
  input  logic [mse_pkg::REG_AW-1:0] rb_addr,
  output logic [mse_pkg::XLEN-1:0]   ra_data,
  output logic [mse_pkg::XLEN-1:0]   rb_data,
  input  logic                       wr_en,
  input  logic [mse_pkg::REG_AW-1:0] wr_addr,
  input  logic [mse_pkg::XLEN-1:0]   wr_data
);
  import mse_pkg::*;

  logic [XLEN-1:0]  mem [NREGS];
  logic [NREGS-1:0] vld_r;
  logic [XLEN-1:0]  ra_q_r;
  logic [XLEN-1:0]  rb_q_r;
  logic             ra_v_r;
  logic             rb_v_r;

  // Mark written entries valid
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (wr_en) begin
      vld_r[wr_addr] <= 1'b1;
    end
  end

  // Write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Read ports; pass a same-edge write through to the read register
  always_ff @(posedge clk) begin
    if (rd_en) begin
      if (wr_en && wr_addr == ra_addr) begin
        ra_q_r <= wr_data;
        ra_v_r <= 1'b1;
      end else begin
        ra_q_r <= mem[ra_addr];
        ra_v_r <= vld_r[ra_addr];
      end
      if (wr_en && wr_addr == rb_addr) begin
        rb_q_r <= wr_data;
        rb_v_r <= 1'b1;
      end else begin
        rb_q_r <= mem[rb_addr];
        rb_v_r <= vld_r[rb_addr];
      end
    end
  end

  assign ra_data = ra_v_r ? ra_q_r : '0;
  assign rb_data = rb_v_r ? rb_q_r : '0;

`ifndef ASSERT_OFF
  // Register zero must never be written
  a_no_zero_write: assert property (@(posedge clk) disable iff (!rst_n)
    wr_en |-> wr_addr != '0)
    else $error("register zero written");
`endif

endmodule

// ----- src/mse_dmem.sv -----
// ----------------------------------------------------------------------------
// mse_dmem
// Word data memory with registered read data. After reset a sweep writes
// zero to every word, one per cycle; busy stays high until it finishes.
// ----------------------------------------------------------------------------
module mse_dmem (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        rd_en,
  input  logic                        wr_en,
  input  logic [mse_pkg::DMEM_AW-1:0] addr,
  input  logic [mse_pkg::XLEN-1:0]    wr_data,
  output logic [mse_pkg::XLEN-1:0]    rd_data,
  output logic                        busy
);
  import mse_pkg::*;

  logic [XLEN-1:0]    mem [DMEM_DEPTH];
  logic [XLEN-1:0]    rd_q_r;
  logic               clr_busy_r;
  logic [DMEM_AW-1:0] clr_cnt_r;

  // Clear sweep control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_busy_r <= 1'b1;
      clr_cnt_r  <= '0;
    end else if (clr_busy_r) begin
      clr_cnt_r <= clr_cnt_r + 1'b1;
      if (clr_cnt_r == DMEM_AW'(DMEM_DEPTH - 1)) begin
        clr_busy_r <= 1'b0;
      end
    end
  end

  // Write port: sweep zeros first, then stores
  always_ff @(posedge clk) begin
    if (clr_busy_r) begin
      mem[clr_cnt_r] <= '0;
    end else if (wr_en) begin
      mem[addr] <= wr_data;
    end
  end

  // Registered read
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_q_r <= mem[addr];
    end
  end

  assign rd_data = rd_q_r;
  assign busy    = clr_busy_r;

`ifndef ASSERT_OFF
  // No access may slip in while the sweep owns the write port
  a_idle_during_clear: assert property (@(posedge clk) disable iff (!rst_n)
    clr_busy_r |-> !wr_en && !rd_en)
    else $error("data memory accessed during clear");
`endif

endmodule

// ----- src/mse_alu.sv -----
// ----------------------------------------------------------------------------
// mse_alu
// Execute stage logic: register result, load/store address and branch
// decision for one decoded instruction.
// ----------------------------------------------------------------------------
module mse_alu (
  input  mse_pkg::op_t               op,
  input  logic [mse_pkg::REG_AW-1:0] rd,
  input  logic [mse_pkg::XLEN-1:0]   ra,
  input  logic [mse_pkg::XLEN-1:0]   rb,
  input  logic [mse_pkg::XLEN-1:0]   imm,
  output mse_pkg::exec_t             ex
);
  import mse_pkg::*;

  logic [XLEN-1:0] addr_sum;
  logic            wr;

  // Base plus sign-extended offset; the low bits select the word
  assign addr_sum = ra + sext16(imm);

  // Decode and compute
  always_comb begin
    ex          = '0;
    wr          = 1'b0;
    ex.mem_addr = addr_sum[DMEM_AW-1:0];
    case (op)
      OP_LI: begin
        ex.result = imm;
        wr        = 1'b1;
      end
      OP_MOVE: begin
        ex.result = ra;
        wr        = 1'b1;
      end
      OP_J: begin
        ex.is_br = 1'b1;
        ex.taken = 1'b1;
      end
      OP_ADD: begin
        ex.result = ra + rb;
        wr        = 1'b1;
      end
      OP_AND: begin
        ex.result = ra & rb;
        wr        = 1'b1;
      end
      OP_SLT: begin
        ex.result = {{(XLEN-1){1'b0}}, $signed(ra) < $signed(rb)};
        wr        = 1'b1;
      end
      OP_ADDI: begin
        ex.result = ra + sext16(imm);
        wr        = 1'b1;
      end
      OP_ORI: begin
        ex.result = ra | zext16(imm);
        wr        = 1'b1;
      end
      OP_LUI: begin
        ex.result = {imm[HALF_W-1:0], {(XLEN-HALF_W){1'b0}}};
        wr        = 1'b1;
      end
      OP_LW: begin
        ex.is_load = 1'b1;
        wr         = 1'b1;
      end
      OP_SW: begin
        ex.is_store = 1'b1;
      end
      OP_BEQ: begin
        ex.is_br = 1'b1;
        ex.taken = (rb == ra);
      end
      OP_BNE: begin
        ex.is_br = 1'b1;
        ex.taken = (rb != ra);
      end
      default: begin
      end
    endcase
    // Drop writes to register zero
    ex.wr_en = wr && (rd != '0);
  end

endmodule

// ----- src/mips_subset_execute_unit.sv -----
// ----------------------------------------------------------------------------
// mips_subset_execute_unit
// Executes one decoded MIPS-subset instruction per transfer and reports its
// byte address and branch outcome.
// ----------------------------------------------------------------------------
// Throughput is one instruction per clock while out_ready stays high and the
// memory clear is done; a result passes through the input/execute register
// and then the result register before it is presented. The rate is set by
// the execute stage: register operands come from the register file read
// registers or are forwarded from the result stage, and stores and the
// branch decision complete there while loads issue their read there. After
// reset the data memory is cleared one word per cycle, so in_ready stays low
// until all 1024 words are cleared. Register 0 always reads zero; data
// addresses wrap at 1024 words and the instruction index at 1024 entries.
module mips_subset_execute_unit (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic [mse_pkg::OP_W-1:0]    in_operation,
  input  logic [mse_pkg::REG_AW-1:0]  in_first_reg,
  input  logic [mse_pkg::REG_AW-1:0]  in_second_reg,
  input  logic [mse_pkg::REG_AW-1:0]  in_third_reg,
  input  logic signed [mse_pkg::XLEN-1:0] in_immediate,
  input  logic [mse_pkg::TGT_W-1:0]   in_branch_target,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic [mse_pkg::BADDR_W-1:0] out_instruction_byte_address,
  output logic                        out_is_branch,
  output logic                        out_took_branch
);
  import mse_pkg::*;

  // Execute stage registers
  logic                s1_valid_r;
  op_t                 s1_op_r;
  logic [REG_AW-1:0]   s1_rd_r;
  logic [REG_AW-1:0]   s1_ra_addr_r;
  logic [REG_AW-1:0]   s1_rb_addr_r;
  logic [XLEN-1:0]     s1_imm_r;
  logic [TGT_W-1:0]    s1_tgt_r;

  // Result stage registers
  logic                s2_valid_r;
  logic [BADDR_W-1:0]  s2_baddr_r;
  logic                s2_br_r;
  logic                s2_taken_r;
  logic                s2_wr_r;
  logic                s2_load_r;
  logic [REG_AW-1:0]   s2_rd_r;
  logic [XLEN-1:0]     s2_result_r;

  logic [IMEM_AW-1:0]  idx_r;
  logic [IMEM_AW-1:0]  idx_nxt;

  logic                s2_free;
  logic                s1_adv;
  logic                in_xfer;
  logic                rb_from_first;
  logic [REG_AW-1:0]   in_rb_addr;
  logic                dmem_busy;
  logic [XLEN-1:0]     dmem_rdata;
  logic [XLEN-1:0]     rf_ra;
  logic [XLEN-1:0]     rf_rb;
  logic [XLEN-1:0]     ra_val;
  logic [XLEN-1:0]     rb_val;
  logic [XLEN-1:0]     wb_data;
  logic                wb_en;
  exec_t               ex;

  // Handshake and stage advance
  assign s2_free  = !s2_valid_r || out_ready;
  assign s1_adv   = s1_valid_r && s2_free;
  assign in_ready = !dmem_busy && (!s1_valid_r || s1_adv);
  assign in_xfer  = in_valid && in_ready;

  // Stores, BEQ and BNE take first_reg as rb; everything else reads third_reg
  always_comb begin
    rb_from_first = op_t'(in_operation) inside {OP_SW, OP_BEQ, OP_BNE};
    in_rb_addr    = rb_from_first ? in_first_reg : in_third_reg;
  end

  // Writeback from the result stage, held while the result waits
  assign wb_data = s2_load_r ? dmem_rdata : s2_result_r;
  assign wb_en   = s2_valid_r && s2_wr_r;

  mse_regfile u_regfile (
    .clk     (clk),
    .rst_n   (rst_n),
    .rd_en   (in_xfer),
    .ra_addr (in_second_reg),
    .rb_addr (in_rb_addr),
    .ra_data (rf_ra),
    .rb_data (rf_rb),
    .wr_en   (wb_en),
    .wr_addr (s2_rd_r),
    .wr_data (wb_data)
  );

  // Forward the previous instruction's result
  assign ra_val = (wb_en && s2_rd_r == s1_ra_addr_r) ? wb_data : rf_ra;
  assign rb_val = (wb_en && s2_rd_r == s1_rb_addr_r) ? wb_data : rf_rb;

  mse_alu u_alu (
    .op  (s1_op_r),
    .rd  (s1_rd_r),
    .ra  (ra_val),
    .rb  (rb_val),
    .imm (s1_imm_r),
    .ex  (ex)
  );

  mse_dmem u_dmem (
    .clk     (clk),
    .rst_n   (rst_n),
    .rd_en   (s1_adv),
    .wr_en   (s1_adv && ex.is_store),
    .addr    (ex.mem_addr),
    .wr_data (rb_val),
    .rd_data (dmem_rdata),
    .busy    (dmem_busy)
  );

  // Next instruction index: target when taken, else step and wrap
  assign idx_nxt = ex.taken ? IMEM_AW'(s1_tgt_r) : IMEM_AW'(idx_r + 1'b1);

  // Control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
      s2_valid_r <= 1'b0;
      idx_r      <= '0;
    end else begin
      if (in_xfer) begin
        s1_valid_r <= 1'b1;
      end else if (s1_adv) begin
        s1_valid_r <= 1'b0;
      end
      if (s1_adv) begin
        s2_valid_r <= 1'b1;
        idx_r      <= idx_nxt;
      end else if (out_ready) begin
        s2_valid_r <= 1'b0;
      end
    end
  end

  // Capture the incoming instruction
  always_ff @(posedge clk) begin
    if (in_xfer) begin
      s1_op_r      <= op_t'(in_operation);
      s1_rd_r      <= in_first_reg;
      s1_ra_addr_r <= in_second_reg;
      s1_rb_addr_r <= in_rb_addr;
      s1_imm_r     <= in_immediate;
      s1_tgt_r     <= in_branch_target;
    end
  end

  // Capture the executed result
  always_ff @(posedge clk) begin
    if (s1_adv) begin
      s2_baddr_r  <= BADDR_W'({idx_r, 2'b00});
      s2_br_r     <= ex.is_br;
      s2_taken_r  <= ex.taken;
      s2_wr_r     <= ex.wr_en;
      s2_load_r   <= ex.is_load;
      s2_rd_r     <= s1_rd_r;
      s2_result_r <= ex.result;
    end
  end

  assign out_valid                    = s2_valid_r;
  assign out_instruction_byte_address = s2_baddr_r;
  assign out_is_branch                = s2_br_r;
  assign out_took_branch              = s2_taken_r;

`ifndef ASSERT_OFF
  // Only control-transfer instructions may report a taken branch
  a_taken_is_branch: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_is_branch || !out_took_branch))
    else $error("taken branch on a non-branch instruction");

  // No instruction enters while the data memory is being cleared
  a_no_accept_in_clear: assert property (@(posedge clk) disable iff (!rst_n)
    dmem_busy |-> !in_ready)
    else $error("input accepted during memory clear");

  // Without a taken branch the index steps by one
  a_index_step: assert property (@(posedge clk) disable iff (!rst_n)
    $past(rst_n) && $past(s1_adv) && !$past(ex.taken)
      |-> idx_r == IMEM_AW'($past(idx_r) + 1'b1))
    else $error("instruction index did not advance by one");
`endif

endmodule

// ----- tb/tb_mips_subset_execute_unit.sv -----
// ----------------------------------------------------------------------------
// tb_mips_subset_execute_unit
// Self-checking bench for the MIPS-subset execute unit. A short directed
// table covers the corner cases: zero register, wrap, wide immediates,
// memory round trip, branch to the last index and unused codes. A random
// instruction stream follows. Results are checked against typed-in values
// or an in-bench architectural model, with random idle gaps on both channels.
// ----------------------------------------------------------------------------
module tb_mips_subset_execute_unit;
  timeunit 1ns;
  timeprecision 1ps;

  import mse_pkg::*;

  // Unused opcodes; the block runs them as nop
  localparam logic [OP_W-1:0] OP_UNUSED_A = 4'd14;
  localparam logic [OP_W-1:0] OP_UNUSED_B = 4'd15;
  localparam int RANDOM_ITEMS = 500;

  typedef struct packed {
    logic [OP_W-1:0]   op;
    logic [REG_AW-1:0] r1;
    logic [REG_AW-1:0] r2;
    logic [REG_AW-1:0] r3;
    logic [XLEN-1:0]   imm;
    logic [TGT_W-1:0]  tgt;
  } instr_t;

  typedef struct packed {
    logic [BADDR_W-1:0] addr;
    logic               is_br;
    logic               took;
  } outcome_t;

  typedef struct packed {
    instr_t   ins;
    logic     known;
    outcome_t want;
  } dir_row_t;

  logic                   clk;
  logic                   rst_n;
  logic                   in_valid;
  logic                   in_ready;
  logic [OP_W-1:0]        in_operation;
  logic [REG_AW-1:0]      in_first_reg;
  logic [REG_AW-1:0]      in_second_reg;
  logic [REG_AW-1:0]      in_third_reg;
  logic signed [XLEN-1:0] in_immediate;
  logic [TGT_W-1:0]       in_branch_target;
  logic                   out_valid;
  logic                   out_ready;
  logic [BADDR_W-1:0]     out_instruction_byte_address;
  logic                   out_is_branch;
  logic                   out_took_branch;

  // Architectural state of the model
  logic [XLEN-1:0]    arch_regs [NREGS];
  logic [XLEN-1:0]    data_words [DMEM_DEPTH];
  logic [IMEM_AW-1:0] instr_idx;

  outcome_t expected_results [$];
  dir_row_t directed_rows [25];

  int  fail_count = 0;
  int  n_sent     = 0;
  int  n_checked  = 0;
  int  n_taken    = 0;
  int  n_mem      = 0;
  bit  steady     = 1'b0;
  int  hold_cnt   = 0;

  mips_subset_execute_unit dut (
    .clk                          (clk),
    .rst_n                        (rst_n),
    .in_valid                     (in_valid),
    .in_ready                     (in_ready),
    .in_operation                 (in_operation),
    .in_first_reg                 (in_first_reg),
    .in_second_reg                (in_second_reg),
    .in_third_reg                 (in_third_reg),
    .in_immediate                 (in_immediate),
    .in_branch_target             (in_branch_target),
    .out_valid                    (out_valid),
    .out_ready                    (out_ready),
    .out_instruction_byte_address (out_instruction_byte_address),
    .out_is_branch                (out_is_branch),
    .out_took_branch              (out_took_branch)
  );

  // 2 ns clock
  always begin
    clk = 1'b0;
    #1;
    clk = 1'b1;
    #1;
  end

  task automatic report_mismatch(input string what, input logic [XLEN-1:0] got,
                                 input logic [XLEN-1:0] want);
    $display("[%0t] MISMATCH %s: got 0x%0h, expected 0x%0h", $realtime, what, got, want);
    fail_count++;
  endtask

  // Execute one instruction on the model state and return its outcome
  function automatic outcome_t execute_instr(input instr_t it);
    outcome_t        res;
    logic [XLEN-1:0] a1, a2, a3, simm, ea, wval;
    logic            wen, taken;
    a1    = arch_regs[it.r1];
    a2    = arch_regs[it.r2];
    a3    = arch_regs[it.r3];
    simm  = {{(XLEN-HALF_W){it.imm[HALF_W-1]}}, it.imm[HALF_W-1:0]};
    ea    = a2 + simm;
    wen   = 1'b1;
    taken = 1'b0;
    wval  = '0;
    res.is_br = 1'b0;
    case (it.op)
      OP_LI:   wval = it.imm;
      OP_MOVE: wval = a2;
      OP_J: begin
        wen = 1'b0; res.is_br = 1'b1; taken = 1'b1;
      end
      OP_ADD:  wval = a2 + a3;
      OP_AND:  wval = a2 & a3;
      OP_SLT:  wval = ($signed(a2) < $signed(a3)) ? 32'd1 : 32'd0;
      OP_ADDI: wval = a2 + simm;
      OP_ORI:  wval = a2 | {{(XLEN-HALF_W){1'b0}}, it.imm[HALF_W-1:0]};
      OP_LUI:  wval = {it.imm[HALF_W-1:0], {HALF_W{1'b0}}};
      OP_LW:   wval = data_words[ea[DMEM_AW-1:0]];
      OP_SW: begin
        wen = 1'b0;
        data_words[ea[DMEM_AW-1:0]] = a1;
      end
      OP_BEQ: begin
        wen = 1'b0; res.is_br = 1'b1; taken = (a1 == a2);
      end
      OP_BNE: begin
        wen = 1'b0; res.is_br = 1'b1; taken = (a1 != a2);
      end
      default: wen = 1'b0;
    endcase
    // Drop writes to the zero register
    if (wen && it.r1 != '0) arch_regs[it.r1] = wval;
    res.addr = {instr_idx, 2'b00};
    res.took = taken;
    instr_idx = taken ? it.tgt : instr_idx + 1'b1;
    return res;
  endfunction

  function automatic dir_row_t dir_row(input logic [OP_W-1:0] op, input int r1, input int r2,
                                       input int r3, input logic [XLEN-1:0] imm,
                                       input int tgt, input bit known, input int addr,
                                       input bit is_br, input bit took);
    dir_row_t row;
    row.ins   = '{op: op, r1: REG_AW'(r1), r2: REG_AW'(r2), r3: REG_AW'(r3), imm: imm,
                  tgt: TGT_W'(tgt)};
    row.known = known;
    row.want  = '{addr: BADDR_W'(addr), is_br: is_br, took: took};
    return row;
  endfunction

  // Mostly short gaps, a few long ones, none while in steady mode
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 19);
    if (steady || r < 12) return 0;
    if (r < 18) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // Favor a few low registers so results feed the next instructions
  function automatic logic [REG_AW-1:0] pick_reg();
    if ($urandom_range(0, 3) == 0) return REG_AW'($urandom_range(0, NREGS - 1));
    return REG_AW'($urandom_range(0, 7));
  endfunction

  function automatic logic [XLEN-1:0] pick_imm();
    logic [XLEN-1:0] v;
    v = $urandom;
    case ($urandom_range(0, 4))
      0: return v;
      1: return $urandom_range(0, 15);
      2: return -$urandom_range(1, 16);
      3: begin
        case ($urandom_range(0, 3))
          0: v[HALF_W-1:0] = 16'h0000;
          1: v[HALF_W-1:0] = 16'h7FFF;
          2: v[HALF_W-1:0] = 16'h8000;
          default: v[HALF_W-1:0] = 16'hFFFF;
        endcase
        return v;
      end
      default: return {16'(v), 16'($urandom)};
    endcase
  endfunction

  function automatic instr_t random_instr();
    instr_t it;
    int     k;
    it.r1  = pick_reg();
    it.r2  = pick_reg();
    it.r3  = pick_reg();
    it.imm = pick_imm();
    it.tgt = TGT_W'($urandom_range(0, IMEM_DEPTH - 1));
    k = $urandom_range(0, 99);
    if (k < 10) begin
      it.op = OP_W'($urandom_range(0, 15));
    end else if (k < 30) begin
      // Keep addresses clustered so loads see earlier stores
      it.op = (k < 20) ? OP_SW : OP_LW;
      if ($urandom_range(0, 2) != 0) it.imm = $urandom_range(0, 15);
    end else if (k < 48) begin
      case ($urandom_range(0, 2))
        0: it.op = OP_J;
        1: it.op = OP_BEQ;
        default: it.op = OP_BNE;
      endcase
      if ($urandom_range(0, 4) < 2) it.r2 = it.r1;
    end else begin
      case ($urandom_range(0, 7))
        0: it.op = OP_LI;
        1: it.op = OP_MOVE;
        2: it.op = OP_ADD;
        3: it.op = OP_AND;
        4: it.op = OP_SLT;
        5: it.op = OP_ADDI;
        6: it.op = OP_ORI;
        default: it.op = OP_LUI;
      endcase
    end
    return it;
  endfunction

  // Present one instruction after an idle gap, hold it until the transfer,
  // then queue what it should produce. Enter and leave on a falling edge.
  task automatic send_instr(input instr_t it, input bit known, input outcome_t want,
                            input int gap);
    outcome_t predicted;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid         <= 1'b1;
    in_operation     <= it.op;
    in_first_reg     <= it.r1;
    in_second_reg    <= it.r2;
    in_third_reg     <= it.r3;
    in_immediate     <= it.imm;
    in_branch_target <= it.tgt;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    predicted = execute_instr(it);
    expected_results = {expected_results, (known ? want : predicted)};
    n_sent++;
    if (predicted.took) n_taken++;
    if (it.op == OP_LW || it.op == OP_SW) n_mem++;
    @(negedge clk);
  endtask

  // Result side: random stalls, none in steady mode
  initial begin
    out_ready = 1'b0;
    @(posedge rst_n);
    forever begin
      @(negedge clk);
      if (hold_cnt > 0) begin
        out_ready <= 1'b0;
        hold_cnt--;
      end else begin
        out_ready <= 1'b1;
        if (!steady && $urandom_range(0, 3) == 0) hold_cnt = pick_gap();
      end
    end
  end

  // Compare each result transfer with the oldest expectation
  always @(posedge clk) begin
    outcome_t want;
    if (rst_n && out_valid && out_ready) begin
      if (expected_results.size() == 0) begin
        report_mismatch("result with nothing expected",
                        XLEN'(out_instruction_byte_address), '0);
      end else begin
        want = expected_results.pop_front();
        n_checked++;
        if (out_instruction_byte_address !== want.addr)
          report_mismatch("instruction_byte_address", XLEN'(out_instruction_byte_address),
                          XLEN'(want.addr));
        if (out_is_branch !== want.is_br)
          report_mismatch("branch flag", XLEN'(out_is_branch), XLEN'(want.is_br));
        if (out_took_branch !== want.took)
          report_mismatch("taken flag", XLEN'(out_took_branch), XLEN'(want.took));
      end
    end
  end

  // Stimulus
  initial begin
    instr_t it;
    rst_n            = 1'b0;
    in_valid         = 1'b0;
    in_operation     = OP_NOP;
    in_first_reg     = '0;
    in_second_reg    = '0;
    in_third_reg     = '0;
    in_immediate     = '0;
    in_branch_target = '0;
    foreach (arch_regs[i]) arch_regs[i] = '0;
    foreach (data_words[i]) data_words[i] = '0;
    instr_idx = '0;

    // Corner cases; expectations typed in only where obvious
    directed_rows = '{
      dir_row(OP_NOP,  0, 0, 0, 32'h0,        0,    1, 0,    0, 0),
      dir_row(OP_LI,   1, 0, 0, 32'h7FFFFFFF, 0,    0, 0,    0, 0),
      dir_row(OP_LI,   2, 0, 0, 32'h80000000, 0,    0, 0,    0, 0),
      dir_row(OP_LI,   0, 0, 0, 32'hFFFFFFFF, 0,    0, 0,    0, 0),
      dir_row(OP_ADD,  3, 1, 2, 32'h0,        0,    0, 0,    0, 0),
      dir_row(OP_ADD,  4, 1, 1, 32'h0,        0,    0, 0,    0, 0),
      dir_row(OP_AND,  5, 3, 2, 32'h0,        0,    0, 0,    0, 0),
      dir_row(OP_SLT,  6, 2, 1, 32'h0,        0,    0, 0,    0, 0),
      dir_row(OP_SLT,  7, 1, 2, 32'h0,        0,    0, 0,    0, 0),
      dir_row(OP_ADDI, 8, 1, 0, 32'h12348000, 0,    0, 0,    0, 0),
      dir_row(OP_ADDI, 9, 0, 0, 32'h00007FFF, 0,    0, 0,    0, 0),
      dir_row(OP_ORI,  10, 2, 0, 32'hFFFFFFFF, 0,   0, 0,    0, 0),
      dir_row(OP_LUI,  11, 0, 0, 32'hABCD1234, 0,   0, 0,    0, 0),
      dir_row(OP_MOVE, 12, 3, 0, 32'h0,        0,   0, 0,    0, 0),
      dir_row(OP_SW,   3, 1, 0, 32'h0000FFFF, 0,    0, 0,    0, 0),
      dir_row(OP_LW,   13, 1, 0, 32'hFFFFFFFF, 0,   0, 0,    0, 0),
      dir_row(OP_LW,   14, 9, 0, 32'h0,        0,   0, 0,    0, 0),
      dir_row(OP_BEQ,  0, 0, 0, 32'h0,        1023, 1, 68,   1, 1),
      dir_row(OP_NOP,  0, 0, 0, 32'h0,        0,    1, 4092, 0, 0),
      dir_row(OP_BNE,  0, 0, 0, 32'h0,        5,    1, 0,    1, 0),
      dir_row(OP_BNE,  1, 2, 0, 32'h0,        0,    0, 0,    0, 0),
      dir_row(OP_J,    0, 0, 0, 32'h0,        512,  0, 0,    0, 0),
      dir_row(OP_UNUSED_A, 31, 31, 31, 32'hFFFFFFFF, 1023, 0, 0, 0, 0),
      dir_row(OP_UNUSED_B, 31, 31, 31, 32'h0,        0,    0, 0, 0, 0),
      dir_row(OP_BEQ,  13, 3, 0, 32'h0,       100,  0, 0,    0, 0)
    };

    // Hold reset, then release on a falling edge
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    foreach (directed_rows[i])
      send_instr(directed_rows[i].ins, directed_rows[i].known, directed_rows[i].want,
                 pick_gap());

    // Random stream; a middle stretch runs with no idling on either side
    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      steady = (n >= 200 && n < 300);
      it = random_instr();
      send_instr(it, 1'b0, '0, pick_gap());
    end
    steady = 1'b0;
    in_valid <= 1'b0;

    // Drain, then keep watching for any stray result
    while (expected_results.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);

    $display("Ran %0d instructions, checked %0d results (%0d taken branches, %0d loads/stores)",
             n_sent, n_checked, n_taken, n_mem);
    if (fail_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #1_000_000;
    $display("Timeout with %0d results still outstanding", expected_results.size());
    $display("Test completed with failures");
    $finish;
  end

endmodule
